[hdl/htlp_pkg.sv]
// Shared types and constants for the linear probing hash table.
// Used by htlp_rem, htlp_mem and hash_table_linear_probe; depends on nothing.
package htlp_pkg;

	localparam int TABLE_DEPTH_DEF = 16;

	localparam int KEY_W  = 31;
	localparam int NAME_W = 8;
	localparam int SIZE_W = 5;
	localparam int SLOT_W = 4;

	// bit counts handed to the remainder unit
	localparam logic [SIZE_W-1:0] KEY_BITS = 5'd31;
	localparam logic [SIZE_W-1:0] IDX_BITS = 5'd5;

	localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 5'd16;
	localparam logic [SIZE_W-1:0] HASH_DIV_RST   = 5'd10;
	localparam logic              REPLACE_RST    = 1'b1;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_KEY_ZERO = 2'd2;

	typedef enum logic [1:0] {
		CFG_TABLE_SIZE = 2'd0,
		CFG_HASH_DIV   = 2'd1,
		CFG_REPLACE    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic              cmd;
		logic [KEY_W-1:0]  key;
		logic [NAME_W-1:0] name_code;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              found;
		logic [SLOT_W-1:0] slot;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [NAME_W-1:0] name;
	} entry_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_HASH1,
		ST_HASH2,
		ST_PROBE_RD,
		ST_PROBE_CHK,
		ST_REHASH1,
		ST_REHASH2,
		ST_WR_NEW,
		ST_WR_OLD
	} fsm_t;

endpackage

[hdl/htlp_rem.sv]
// Bit-serial remainder unit: one restoring step per cycle, MSB first.
// Depends on htlp_pkg for widths.
module htlp_rem (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic [htlp_pkg::KEY_W-1:0]     dividend,
	input  logic [htlp_pkg::SIZE_W-1:0]    nbits,
	input  logic [htlp_pkg::SIZE_W-1:0]    divisor,
	output logic                           done,
	output logic [htlp_pkg::SIZE_W-1:0]    rem
);
	import htlp_pkg::*;

	logic [KEY_W-1:0]  dvd_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W-1:0] dsr_q;
	logic [SIZE_W-1:0] cnt_q;
	logic              run_q;
	logic              done_q;

	logic [SIZE_W:0]   trial;
	logic [SIZE_W:0]   diff;
	logic              ge;

	// remainder stays below the divisor, so the trial value fits one extra bit
	always_comb begin
		trial = {rem_q, dvd_q[KEY_W-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = trial >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= nbits;
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
			rem_q <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

[hdl/htlp_mem.sv]
// Slot store: one write port, one read port with registered read data.
// Depends on htlp_pkg for the entry type.
module htlp_mem #(
	parameter int DEPTH = htlp_pkg::TABLE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  htlp_pkg::entry_t           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output htlp_pkg::entry_t           rdata
);
	import htlp_pkg::*;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/hash_table_linear_probe.sv]
// Open-addressed hash table with linear probing and optional relocation.
// Top level; depends on htlp_pkg, htlp_rem and htlp_mem.
//
// Usage: present a transaction on req and raise start; it is taken on a rising
// edge where start is high and busy is low. cmd selects insert or search.
// Each transaction gives exactly one result on rsp, marked by done for one
// cycle; the receiver cannot stall it. Registers are written through cfg_we /
// cfg_idx / cfg_wdata, by the user only while busy is low; no check in the block.
// A zero key is answered straight from idle. Otherwise the shared bit-serial
// remainder unit forms the home slot, 31 steps for the key and 5 for the
// reduction to the table size; slots are then probed in turn, each through a
// read and a check state on the single read port. A search answers on a match
// or once every slot is probed, an insert once it writes a free slot, and a
// full table once every slot is probed. Relocating an occupant runs the
// remainder unit again and adds a second write. One transaction at a time;
// busy is low again while done is high, so the next can be taken as the result is shown.
// Reset: a clearing pass writes every slot empty, one a cycle; busy is high
// meanwhile. Registers return to 16, 10, 1.
module hash_table_linear_probe #(
	parameter int TABLE_DEPTH = htlp_pkg::TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  htlp_pkg::req_t                req,
	output logic                          done,
	output htlp_pkg::rsp_t                rsp,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_idx,
	input  logic [htlp_pkg::SIZE_W-1:0]   cfg_wdata
);
	import htlp_pkg::*;

	localparam int IW   = $clog2(TABLE_DEPTH);
	localparam int NMAX = (TABLE_DEPTH < 31) ? TABLE_DEPTH : 31;
	localparam logic [SIZE_W-1:0] NMAX_V   = SIZE_W'(NMAX);
	localparam logic [IW-1:0]     CLR_LAST = IW'(TABLE_DEPTH - 1);

	fsm_t state_q, state_d;

	logic [SIZE_W-1:0] table_size_q;
	logic [SIZE_W-1:0] hash_div_q;
	logic              replace_q;

	logic [SIZE_W-1:0] n_act;
	logic [SIZE_W-1:0] div_act;

	logic              cmd_q;
	logic [KEY_W-1:0]  key_q;
	logic [NAME_W-1:0] name_q;
	logic [SIZE_W-1:0] h_q;
	logic [SIZE_W-1:0] idx_q;
	logic [SIZE_W-1:0] cnt_q;
	logic [SIZE_W-1:0] f_q;
	logic [SIZE_W-1:0] tgt_q;
	logic              ev_q;
	entry_t            home_q;
	logic [IW-1:0]     clr_q;

	logic [SIZE_W-1:0] idx_inc;
	logic [SIZE_W-1:0] idx_nxt;
	logic              probe_last;

	logic              mem_we;
	logic [IW-1:0]     mem_waddr;
	entry_t            mem_wdata;
	entry_t            mem_rdata;

	logic              rem_go;
	logic [KEY_W-1:0]  rem_dvd;
	logic [SIZE_W-1:0] rem_nbits;
	logic [SIZE_W-1:0] rem_div;
	logic              rem_done;
	logic [SIZE_W-1:0] rem_val;

	logic              fin;
	rsp_t              rsp_d;
	logic              done_q;
	rsp_t              rsp_q;

	htlp_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (rem_go),
		.dividend (rem_dvd),
		.nbits    (rem_nbits),
		.divisor  (rem_div),
		.done     (rem_done),
		.rem      (rem_val)
	);

	htlp_mem #(
		.DEPTH (TABLE_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (IW'(idx_q)),
		.rdata (mem_rdata)
	);

	// effective size and divisor: zero acts as one, size clamps to the store
	always_comb begin
		if (table_size_q == '0) begin
			n_act = 5'd1;
		end else if (table_size_q > NMAX_V) begin
			n_act = NMAX_V;
		end else begin
			n_act = table_size_q;
		end
		div_act    = (hash_div_q == '0) ? 5'd1 : hash_div_q;
		idx_inc    = idx_q + 5'd1;
		idx_nxt    = (idx_inc == n_act) ? '0 : idx_inc;
		probe_last = cnt_q == (n_act - 5'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TABLE_SIZE_RST;
			hash_div_q   <= HASH_DIV_RST;
			replace_q    <= REPLACE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_TABLE_SIZE: table_size_q <= cfg_wdata;
				CFG_HASH_DIV:   hash_div_q   <= cfg_wdata;
				CFG_REPLACE:    replace_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == ST_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		rem_go    = 1'b0;
		rem_dvd   = '0;
		rem_nbits = KEY_BITS;
		rem_div   = div_act;
		fin       = 1'b0;
		rsp_d     = '0;
		case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (req.key == '0) begin
						fin          = 1'b1;
						rsp_d.status = STATUS_KEY_ZERO;
					end else begin
						rem_go  = 1'b1;
						rem_dvd = req.key;
						state_d = ST_HASH1;
					end
				end
			end
			ST_HASH1, ST_REHASH1: begin
				// second pass: reduce key mod divisor by the table size
				rem_div = n_act;
				if (rem_done) begin
					rem_go    = 1'b1;
					rem_dvd   = {rem_val, {(KEY_W - SIZE_W){1'b0}}};
					rem_nbits = IDX_BITS;
					state_d   = (state_q == ST_HASH1) ? ST_HASH2 : ST_REHASH2;
				end
			end
			ST_HASH2: begin
				if (rem_done) begin
					state_d = ST_PROBE_RD;
				end
			end
			ST_PROBE_RD: begin
				state_d = ST_PROBE_CHK;
			end
			ST_PROBE_CHK: begin
				if (cmd_q == CMD_SEARCH) begin
					if (mem_rdata.key == key_q) begin
						fin         = 1'b1;
						rsp_d.found = 1'b1;
						rsp_d.slot  = SLOT_W'(idx_q);
						state_d     = ST_IDLE;
					end else if (probe_last) begin
						fin     = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_PROBE_RD;
					end
				end else begin
					if (mem_rdata.key == '0) begin
						if (cnt_q == '0 || !replace_q) begin
							state_d = ST_WR_NEW;
						end else begin
							// home occupied: check whether its occupant is at home
							rem_go  = 1'b1;
							rem_dvd = home_q.key;
							state_d = ST_REHASH1;
						end
					end else if (probe_last) begin
						fin          = 1'b1;
						rsp_d.status = STATUS_FULL;
						state_d      = ST_IDLE;
					end else begin
						state_d = ST_PROBE_RD;
					end
				end
			end
			ST_REHASH2: begin
				if (rem_done) begin
					state_d = ST_WR_NEW;
				end
			end
			ST_WR_NEW: begin
				mem_we         = 1'b1;
				mem_waddr      = IW'(tgt_q);
				mem_wdata.key  = key_q;
				mem_wdata.name = name_q;
				if (ev_q) begin
					state_d = ST_WR_OLD;
				end else begin
					fin        = 1'b1;
					rsp_d.slot = SLOT_W'(tgt_q);
					state_d    = ST_IDLE;
				end
			end
			ST_WR_OLD: begin
				// evicted occupant goes to the first free slot past home
				mem_we     = 1'b1;
				mem_waddr  = IW'(f_q);
				mem_wdata  = home_q;
				fin        = 1'b1;
				rsp_d.slot = SLOT_W'(h_q);
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			rsp_q <= rsp_d;
		end
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_q  <= req.cmd;
					key_q  <= req.key;
					name_q <= req.name_code;
				end
			end
			ST_HASH2: begin
				if (rem_done) begin
					h_q   <= rem_val;
					idx_q <= rem_val;
					cnt_q <= '0;
				end
			end
			ST_PROBE_CHK: begin
				if (cnt_q == '0) begin
					home_q <= mem_rdata;
				end
				if (cmd_q == CMD_INSERT && mem_rdata.key == '0) begin
					f_q   <= idx_q;
					tgt_q <= idx_q;
					ev_q  <= 1'b0;
				end else begin
					idx_q <= idx_nxt;
					cnt_q <= cnt_q + 5'd1;
				end
			end
			ST_REHASH2: begin
				if (rem_done && rem_val != h_q) begin
					tgt_q <= h_q;
					ev_q  <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign busy = state_q != ST_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
